/* rtl/pidts_pkg.sv */
package pidts_pkg;

   // field widths
   localparam int HEADING_W   = 24;
   localparam int GAIN_W      = 16;
   localparam int ELAPSED_W   = 10;
   localparam int DRIVE_W     = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   // internal arithmetic widths
   localparam int ERR_W    = HEADING_W + 1;
   localparam int DERIV_W  = ERR_W + 1;
   localparam int SUM_W    = 32;
   localparam int P_PROD_W = GAIN_W + 1 + ERR_W;
   localparam int I_PROD_W = GAIN_W + 1 + SUM_W;
   localparam int D_PROD_W = GAIN_W + 1 + DERIV_W;
   localparam int ACC_W    = I_PROD_W + 2;

   // loop constants
   localparam int GAIN_SHIFT  = 16;
   localparam int QUO_W       = ACC_W - GAIN_SHIFT;
   localparam int DRIVE_LIMIT = 85;
   localparam int SETTLE_BAND = 4;
   localparam int IZONE_LIMIT = 200;

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_HEADING = 2'd0,
      CSR_KP_GAIN        = 2'd1,
      CSR_KI_GAIN        = 2'd2,
      CSR_KD_GAIN        = 2'd3
   } csr_index_type;

   // beat leaving the error and integral stage
   typedef struct packed {
      logic signed [ERR_W-1:0]   err;
      logic signed [SUM_W-1:0]   error_sum;
      logic signed [DERIV_W-1:0] deriv;
      logic [ELAPSED_W-1:0]      elapsed_ms;
      logic                      restart;
   } loop_beat_type;

   // beat leaving the product stage
   typedef struct packed {
      logic signed [P_PROD_W-1:0] p_term;
      logic signed [I_PROD_W-1:0] i_term;
      logic signed [D_PROD_W-1:0] d_term;
      logic [ELAPSED_W-1:0]       elapsed_ms;
      logic                       restart;
   } prod_beat_type;

   // beat leaving the scale and clamp stage
   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic [ELAPSED_W-1:0]      elapsed_ms;
      logic                      restart;
   } drive_beat_type;

endpackage

/* rtl/pid_turn_with_settle_detect.sv */
// Heading turn controller: PID loop with integral zone, drive clamp and settle detection.
// Request channel (req_valid/req_ready) carries a measured heading in hundredths of a
// degree, the milliseconds since the previous beat and a restart flag that opens a new turn.
// Response channel (rsp_valid/rsp_ready) returns one beat per request: left and right
// drives, opposite in sign and clamped to +-85, and turn_done, which forces both drives to
// zero once the settle countdown has run out.
// The csr_ port writes the target heading or one of the three gains; write only when idle.
// Pipeline: error and integral, gain products, scale and clamp, settle and result register.
// A request beat passes the input, product, drive and result registers in that order.
// One beat per cycle is sustained while rsp_ready stays high, as every stage reloads in the
// cycle its successor empties.
// Reset clears config registers, integral, last error, settle state and all stage valids.
// When the receiver stalls, the result register holds and the stages behind it keep
// filling until each holds a beat; req_ready then falls, and every stage resumes the
// cycle rsp_ready returns.
module pid_turn_with_settle_detect #(
   parameter int SETTLE_DELAY_MS = 300
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [pidts_pkg::HEADING_W-1:0] req_measured_heading,
   input  logic [pidts_pkg::ELAPSED_W-1:0]        req_elapsed_ms,
   input  logic                                   req_restart,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [pidts_pkg::DRIVE_W-1:0]   rsp_left_drive,
   output logic signed [pidts_pkg::DRIVE_W-1:0]   rsp_right_drive,
   output logic                                   rsp_turn_done,
   input  logic                                   csr_write_en,
   input  logic [pidts_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pidts_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int GainW = pidts_pkg::GAIN_W;

   logic signed [pidts_pkg::HEADING_W-1:0] target_ff;
   logic [GainW-1:0]                       kp_ff, ki_ff, kd_ff;
   logic                                   loop_valid, loop_ready;
   logic                                   mac_valid, mac_ready;
   pidts_pkg::loop_beat_type               loop_beat;
   pidts_pkg::drive_beat_type              mac_beat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         kp_ff     <= '0;
         ki_ff     <= '0;
         kd_ff     <= '0;
      end else if (csr_write_en) begin
         unique case (pidts_pkg::csr_index_type'(csr_index))
            pidts_pkg::CSR_TARGET_HEADING: target_ff <= csr_wdata;
            pidts_pkg::CSR_KP_GAIN:        kp_ff     <= csr_wdata[GainW-1:0];
            pidts_pkg::CSR_KI_GAIN:        ki_ff     <= csr_wdata[GainW-1:0];
            pidts_pkg::CSR_KD_GAIN:        kd_ff     <= csr_wdata[GainW-1:0];
            default: ;
         endcase
      end
   end

   pidts_loop u_loop (
      .clock            (clock),
      .reset            (reset),
      .target_heading   (target_ff),
      .in_valid         (req_valid),
      .in_ready         (req_ready),
      .measured_heading (req_measured_heading),
      .elapsed_ms       (req_elapsed_ms),
      .restart          (req_restart),
      .out_valid        (loop_valid),
      .out_ready        (loop_ready),
      .out_beat         (loop_beat)
   );

   pidts_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .kp_gain   (kp_ff),
      .ki_gain   (ki_ff),
      .kd_gain   (kd_ff),
      .in_valid  (loop_valid),
      .in_ready  (loop_ready),
      .in_beat   (loop_beat),
      .out_valid (mac_valid),
      .out_ready (mac_ready),
      .out_beat  (mac_beat)
   );

   pidts_settle #(
      .SETTLE_DELAY_MS (SETTLE_DELAY_MS)
   ) u_settle (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (mac_valid),
      .in_ready        (mac_ready),
      .in_beat         (mac_beat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_right_drive (rsp_right_drive),
      .rsp_turn_done   (rsp_turn_done)
   );

endmodule

/* rtl/pidts_loop.sv */
module pidts_loop (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic signed [pidts_pkg::HEADING_W-1:0]     target_heading,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  logic signed [pidts_pkg::HEADING_W-1:0]     measured_heading,
   input  logic [pidts_pkg::ELAPSED_W-1:0]            elapsed_ms,
   input  logic                                       restart,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output pidts_pkg::loop_beat_type                   out_beat
);

   localparam int ErrW   = pidts_pkg::ERR_W;
   localparam int SumW   = pidts_pkg::SUM_W;
   localparam int DerivW = pidts_pkg::DERIV_W;

   logic                       valid_ff, valid_in;
   logic                       load;
   logic signed [SumW-1:0]     error_sum_ff, error_sum_in;
   logic signed [ErrW-1:0]     last_error_ff;
   logic signed [ErrW-1:0]     err;
   logic signed [SumW:0]       sum_wide;
   logic signed [SumW-1:0]     sum_sat;
   logic signed [DerivW-1:0]   deriv;
   logic                       in_zone;
   pidts_pkg::loop_beat_type   beat_ff, beat_in;

   assign in_ready  = !valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   // heading error and derivative
   assign err   = {target_heading[pidts_pkg::HEADING_W-1], target_heading}
                - {measured_heading[pidts_pkg::HEADING_W-1], measured_heading};
   assign deriv = {err[ErrW-1], err} - {last_error_ff[ErrW-1], last_error_ff};

   // saturating integral with zone reset
   always_comb begin
      sum_wide = {error_sum_ff[SumW-1], error_sum_ff}
               + {{(SumW + 1 - ErrW){err[ErrW-1]}}, err};
      if (sum_wide[SumW] != sum_wide[SumW-1]) begin
         sum_sat = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SumW-1:0];
      end
      in_zone = (err != '0)
             && (err <= $signed(ErrW'(pidts_pkg::IZONE_LIMIT)))
             && (err >= $signed(ErrW'(-pidts_pkg::IZONE_LIMIT)));
      error_sum_in = in_zone ? sum_sat : '0;
   end

   always_comb begin
      beat_in            = beat_ff;
      beat_in.err        = err;
      beat_in.error_sum  = error_sum_in;
      beat_in.deriv      = deriv;
      beat_in.elapsed_ms = elapsed_ms;
      beat_in.restart    = restart;
      valid_in           = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   // loop state and stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            error_sum_ff  <= error_sum_in;
            last_error_ff <= err;
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat_in;
      end
   end

endmodule

/* rtl/pidts_mac.sv */
module pidts_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pidts_pkg::GAIN_W-1:0]        kp_gain,
   input  logic [pidts_pkg::GAIN_W-1:0]        ki_gain,
   input  logic [pidts_pkg::GAIN_W-1:0]        kd_gain,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  pidts_pkg::loop_beat_type            in_beat,
   output logic                                out_valid,
   input  logic                                out_ready,
   output pidts_pkg::drive_beat_type           out_beat
);

   localparam int AccW   = pidts_pkg::ACC_W;
   localparam int QuoW   = pidts_pkg::QUO_W;
   localparam int Shift  = pidts_pkg::GAIN_SHIFT;
   localparam int DriveW = pidts_pkg::DRIVE_W;

   logic                              prod_valid_ff, prod_valid_in;
   logic                              drive_valid_ff, drive_valid_in;
   logic                              prod_ready, prod_load, drive_load;
   logic signed [pidts_pkg::GAIN_W:0] kp_s, ki_s, kd_s;
   pidts_pkg::prod_beat_type          prod_ff, prod_in;
   pidts_pkg::drive_beat_type         drive_ff, drive_in;
   logic signed [AccW-1:0]            acc;
   logic                              round_up;
   logic signed [QuoW-1:0]            quo;

   // handshake between the two stages
   assign prod_ready     = !drive_valid_ff || out_ready;
   assign in_ready       = !prod_valid_ff || prod_ready;
   assign prod_load      = in_valid && in_ready;
   assign drive_load     = prod_valid_ff && prod_ready;
   assign prod_valid_in  = prod_load ? 1'b1 : (prod_ready ? 1'b0 : prod_valid_ff);
   assign drive_valid_in = drive_load ? 1'b1 : (out_ready ? 1'b0 : drive_valid_ff);
   assign out_valid      = drive_valid_ff;
   assign out_beat       = drive_ff;

   // gain products, each registered
   assign kp_s = {1'b0, kp_gain};
   assign ki_s = {1'b0, ki_gain};
   assign kd_s = {1'b0, kd_gain};

   always_comb begin
      prod_in            = prod_ff;
      prod_in.p_term     = kp_s * in_beat.err;
      prod_in.i_term     = ki_s * in_beat.error_sum;
      prod_in.d_term     = kd_s * in_beat.deriv;
      prod_in.elapsed_ms = in_beat.elapsed_ms;
      prod_in.restart    = in_beat.restart;
   end

   // weighted sum, scale toward zero and clamp
   always_comb begin
      acc      = AccW'(prod_ff.p_term) + AccW'(prod_ff.i_term) + AccW'(prod_ff.d_term);
      round_up = acc[AccW-1] && (acc[Shift-1:0] != '0);
      quo      = $signed(acc[AccW-1:Shift]) + $signed({{(QuoW-1){1'b0}}, round_up});
      drive_in            = drive_ff;
      drive_in.elapsed_ms = prod_ff.elapsed_ms;
      drive_in.restart    = prod_ff.restart;
      if (quo > $signed(QuoW'(pidts_pkg::DRIVE_LIMIT))) begin
         drive_in.drive = DriveW'(pidts_pkg::DRIVE_LIMIT);
      end else if (quo < $signed(QuoW'(-pidts_pkg::DRIVE_LIMIT))) begin
         drive_in.drive = DriveW'(-pidts_pkg::DRIVE_LIMIT);
      end else begin
         drive_in.drive = quo[DriveW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff  <= 1'b0;
         drive_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff  <= prod_valid_in;
         drive_valid_ff <= drive_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_load) begin
         prod_ff <= prod_in;
      end
      if (drive_load) begin
         drive_ff <= drive_in;
      end
   end

endmodule

/* rtl/pidts_settle.sv */
module pidts_settle #(
   parameter int SETTLE_DELAY_MS = 300
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  pidts_pkg::drive_beat_type           in_beat,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pidts_pkg::DRIVE_W-1:0] rsp_left_drive,
   output logic signed [pidts_pkg::DRIVE_W-1:0] rsp_right_drive,
   output logic                                rsp_turn_done
);

   localparam int SettleW  = $clog2(SETTLE_DELAY_MS + 1);
   localparam int ElapsedW = pidts_pkg::ELAPSED_W;
   localparam int CmpW     = (SettleW > ElapsedW) ? SettleW : ElapsedW;
   localparam int DriveW   = pidts_pkg::DRIVE_W;

   logic                     load;
   logic                     valid_ff, valid_in;
   logic                     armed_ff, armed_in;
   logic [SettleW-1:0]       remaining_ff, remaining_in;
   logic                     done_ff, done_in;
   logic                     armed_cur, done_cur;
   logic [SettleW-1:0]       remaining_cur;
   logic [CmpW-1:0]          rem_ext, elapsed_ext;
   logic                     in_band;
   logic signed [DriveW-1:0] left_ff, left_in;
   logic signed [DriveW-1:0] right_ff, right_in;
   logic                     turn_done_ff;

   assign in_ready        = !valid_ff || rsp_ready;
   assign load            = in_valid && in_ready;
   assign valid_in        = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   assign rsp_valid       = valid_ff;
   assign rsp_left_drive  = left_ff;
   assign rsp_right_drive = right_ff;
   assign rsp_turn_done   = turn_done_ff;

   // settle countdown and done flag
   always_comb begin
      armed_cur     = in_beat.restart ? 1'b0 : armed_ff;
      remaining_cur = in_beat.restart ? '0 : remaining_ff;
      done_cur      = in_beat.restart ? 1'b0 : done_ff;
      rem_ext       = CmpW'(remaining_cur);
      elapsed_ext   = CmpW'(in_beat.elapsed_ms);
      remaining_in  = remaining_cur;
      if (armed_cur) begin
         remaining_in = (rem_ext > elapsed_ext) ? SettleW'(rem_ext - elapsed_ext) : '0;
      end
      in_band = (in_beat.drive < $signed(DriveW'(pidts_pkg::SETTLE_BAND)))
             && (in_beat.drive > $signed(DriveW'(-pidts_pkg::SETTLE_BAND)));
      armed_in = armed_cur;
      if (in_band && !armed_cur) begin
         armed_in     = 1'b1;
         remaining_in = SettleW'(SETTLE_DELAY_MS);
      end
      done_in  = done_cur || (armed_in && (remaining_in == '0));
      left_in  = done_in ? '0 : -in_beat.drive;
      right_in = done_in ? '0 : in_beat.drive;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         armed_ff     <= 1'b0;
         remaining_ff <= '0;
         done_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            armed_ff     <= armed_in;
            remaining_ff <= remaining_in;
            done_ff      <= done_in;
         end
      end
   end

   // result beat held until taken
   always_ff @(posedge clock) begin
      if (load) begin
         left_ff      <= left_in;
         right_ff     <= right_in;
         turn_done_ff <= done_in;
      end
   end

endmodule

/* rtl/pidts_checker.sv */
module pidts_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [pidts_pkg::DRIVE_W-1:0]   rsp_left_drive,
   input logic signed [pidts_pkg::DRIVE_W-1:0]   rsp_right_drive,
   input logic                                   rsp_turn_done
);

   localparam int DriveW = pidts_pkg::DRIVE_W;

   // a finished turn drives nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_turn_done |-> (rsp_left_drive == '0) && (rsp_right_drive == '0))
      else $error("turn done with non-zero drive");

   // left and right mirror each other
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_turn_done |-> (rsp_left_drive == -rsp_right_drive))
      else $error("left drive does not mirror right drive");

   // drive stays inside the clamp
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_drive <= $signed(DriveW'(pidts_pkg::DRIVE_LIMIT)))
                 && (rsp_right_drive >= $signed(DriveW'(-pidts_pkg::DRIVE_LIMIT))))
      else $error("drive outside clamp");

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_drive)
                                 && $stable(rsp_right_drive) && $stable(rsp_turn_done))
      else $error("stalled result beat changed");

endmodule

bind pid_turn_with_settle_detect pidts_checker u_checker (.*);

/* sim/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_MS = 300;

   // one response beat
   typedef struct {
      logic signed [pidts_pkg::DRIVE_W-1:0] left;
      logic signed [pidts_pkg::DRIVE_W-1:0] right;
      logic                                 done;
   } drive_result_type;

   logic                                   clock = 1'b0;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_ready;
   logic signed [pidts_pkg::HEADING_W-1:0] req_measured_heading;
   logic [pidts_pkg::ELAPSED_W-1:0]        req_elapsed_ms;
   logic                                   req_restart;
   logic                                   rsp_valid;
   logic                                   rsp_ready;
   logic signed [pidts_pkg::DRIVE_W-1:0]   rsp_left_drive;
   logic signed [pidts_pkg::DRIVE_W-1:0]   rsp_right_drive;
   logic                                   rsp_turn_done;
   logic                                   csr_write_en;
   logic [pidts_pkg::CSR_INDEX_W-1:0]      csr_index;
   logic [pidts_pkg::CSR_DATA_W-1:0]       csr_wdata;

   // loop settings as last written
   logic signed [pidts_pkg::HEADING_W-1:0] cfg_target = '0;
   logic [pidts_pkg::GAIN_W-1:0]           cfg_kp = '0;
   logic [pidts_pkg::GAIN_W-1:0]           cfg_ki = '0;
   logic [pidts_pkg::GAIN_W-1:0]           cfg_kd = '0;

   // controller state mirrored for prediction
   logic signed [pidts_pkg::SUM_W-1:0]     integ_sum = '0;
   logic signed [pidts_pkg::ERR_W-1:0]     prev_err = '0;
   logic                                   settle_armed = 1'b0;
   logic [15:0]                            settle_left_ms = '0;
   logic                                   turn_done_flag = 1'b0;

   drive_result_type                       drive_q[$];

   // idling controls and tallies
   bit                            tx_idle = 1'b0;
   bit                            rx_idle = 1'b0;
   int                            rx_hold_cycles = 0;
   int                            beats_sent = 0;
   int                            beats_checked = 0;
   int                            done_beats = 0;
   int                            clamped_beats = 0;
   int                            input_stalls = 0;
   int                            bad_beats = 0;

   pid_turn_with_settle_detect #(
      .SETTLE_DELAY_MS(SETTLE_MS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_measured_heading(req_measured_heading),
      .req_elapsed_ms(req_elapsed_ms),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_left_drive(rsp_left_drive),
      .rsp_right_drive(rsp_right_drive),
      .rsp_turn_done(rsp_turn_done),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // one control step: integral zone, weighted sum, clamp, settle countdown
   function automatic drive_result_type heading_loop_step(
         logic signed [pidts_pkg::HEADING_W-1:0] meas,
         logic [pidts_pkg::ELAPSED_W-1:0] elapsed,
         logic restart);
      longint           err;
      longint           sum;
      longint           deriv;
      longint           mag;
      longint           acc;
      int               drive;
      drive_result_type r;
      if (restart) begin
         settle_armed   = 1'b0;
         settle_left_ms = '0;
         turn_done_flag = 1'b0;
      end
      if (settle_armed) begin
         settle_left_ms = (settle_left_ms > elapsed) ? settle_left_ms - elapsed : 16'd0;
      end
      err = longint'(cfg_target) - longint'(meas);
      sum = longint'(integ_sum) + err;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      integ_sum = sum[pidts_pkg::SUM_W-1:0];
      deriv = err - longint'(prev_err);
      prev_err = err[pidts_pkg::ERR_W-1:0];
      mag = (err < 0) ? -err : err;
      if (err == 0 || mag > pidts_pkg::IZONE_LIMIT) integ_sum = '0;
      acc = longint'(cfg_kp) * err + longint'(cfg_ki) * longint'(integ_sum) +
            longint'(cfg_kd) * deriv;
      // signed division truncates toward zero
      acc = acc / (64'sd1 <<< pidts_pkg::GAIN_SHIFT);
      if (acc > pidts_pkg::DRIVE_LIMIT) acc = pidts_pkg::DRIVE_LIMIT;
      if (acc < -pidts_pkg::DRIVE_LIMIT) acc = -pidts_pkg::DRIVE_LIMIT;
      drive = int'(acc);
      if (drive < pidts_pkg::SETTLE_BAND && drive > -pidts_pkg::SETTLE_BAND
          && !settle_armed) begin
         settle_armed   = 1'b1;
         settle_left_ms = 16'(SETTLE_MS);
      end
      if (settle_armed && settle_left_ms == 0) turn_done_flag = 1'b1;
      if (turn_done_flag) begin
         r.left  = '0;
         r.right = '0;
         r.done  = 1'b1;
      end else begin
         r.left  = pidts_pkg::DRIVE_W'(-drive);
         r.right = pidts_pkg::DRIVE_W'(drive);
         r.done  = 1'b0;
      end
      return r;
   endfunction

   // one request beat, with a random gap ahead of it when idling is on
   task automatic send_beat(logic signed [pidts_pkg::HEADING_W-1:0] meas,
                            logic [pidts_pkg::ELAPSED_W-1:0] elapsed,
                            logic restart);
      int gap;
      gap = tx_idle ? $urandom_range(0, 15) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid            <= 1'b1;
      req_measured_heading <= meas;
      req_elapsed_ms       <= elapsed;
      req_restart          <= restart;
      do @(posedge clock); while (!req_ready);
      drive_q.push_back(heading_loop_step(meas, elapsed, restart));
      beats_sent++;
   endtask

   // drop valid and wait for every outstanding response
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (drive_q.size() != 0) @(posedge clock);
   endtask

   // write all four registers on consecutive cycles
   task automatic load_loop_settings(logic signed [pidts_pkg::HEADING_W-1:0] target,
                                     logic [pidts_pkg::GAIN_W-1:0] kp,
                                     logic [pidts_pkg::GAIN_W-1:0] ki,
                                     logic [pidts_pkg::GAIN_W-1:0] kd);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= pidts_pkg::CSR_TARGET_HEADING;
      csr_wdata    <= target;
      @(negedge clock);
      csr_index    <= pidts_pkg::CSR_KP_GAIN;
      csr_wdata    <= pidts_pkg::CSR_DATA_W'(kp);
      @(negedge clock);
      csr_index    <= pidts_pkg::CSR_KI_GAIN;
      csr_wdata    <= pidts_pkg::CSR_DATA_W'(ki);
      @(negedge clock);
      csr_index    <= pidts_pkg::CSR_KD_GAIN;
      csr_wdata    <= pidts_pkg::CSR_DATA_W'(kd);
      @(negedge clock);
      csr_write_en <= 1'b0;
      cfg_target = target;
      cfg_kp     = kp;
      cfg_ki     = ki;
      cfg_kd     = kd;
   endtask

   // a turn: restart, heading closing on the target, odd knocks and restarts
   task automatic run_turn(int steps);
      int                              offset;
      logic                            restart;
      logic [pidts_pkg::ELAPSED_W-1:0] elapsed;
      offset = int'($urandom_range(0, 6000)) - 3000;
      for (int k = 0; k < steps; k++) begin
         restart = (k == 0) || ($urandom_range(0, 29) == 0);
         if ($urandom_range(0, 24) == 0) offset = int'($urandom_range(0, 1000)) - 500;
         elapsed = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                : 10'($urandom_range(0, 60));
         send_beat(24'(cfg_target - offset), elapsed, restart);
         offset = (offset * 3) / 4 + int'($urandom_range(0, 2)) - 1;
      end
   endtask

   // field extremes, integral zone edges, settle band edges, countdown expiry
   task automatic test_directed();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      load_loop_settings(24'sd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(-24'sd8388608, 10'd0, 1'b1);
      send_beat(24'sd8388607, 10'd1023, 1'b0);
      send_beat(24'sd1000, 10'd0, 1'b0);
      // zero error arms the countdown, this beat's time ignored
      send_beat(24'sd1000, 10'd17, 1'b0);
      send_beat(24'sd1000, 10'd299, 1'b0);
      // exact expiry, then done holds against a far heading
      send_beat(24'sd1000, 10'd1, 1'b0);
      send_beat(-24'sd8388608, 10'd1023, 1'b0);
      // restart keeps integral, zone limit either side
      send_beat(24'sd850, 10'd5, 1'b1);
      send_beat(24'sd800, 10'd5, 1'b0);
      send_beat(24'sd799, 10'd5, 1'b0);
      send_beat(24'sd1200, 10'd5, 1'b0);
      send_beat(24'sd1201, 10'd5, 1'b0);
      wait_drained();
      // settle band edges: drive of 3 arms, drive of 4 does not
      load_loop_settings(24'sd0, 16'hFFFF, 16'h0000, 16'h0000);
      send_beat(-24'sd4, 10'd10, 1'b1);
      send_beat(24'sd4, 10'd10, 1'b1);
      send_beat(-24'sd5, 10'd10, 1'b1);
      send_beat(24'sd5, 10'd10, 1'b1);
      wait_drained();
      // truncation toward zero on both signs
      load_loop_settings(24'sd0, 16'd100, 16'h0000, 16'h0000);
      send_beat(24'sd1000, 10'd0, 1'b1);
      send_beat(-24'sd1000, 10'd0, 1'b0);
      send_beat(24'sd8388607, 10'd0, 1'b0);
      wait_drained();
      // most negative error with zero gains, then most positive with full gains
      load_loop_settings(-24'sd8388608, 16'h0000, 16'h0000, 16'h0000);
      send_beat(24'sd8388607, 10'd1023, 1'b1);
      send_beat(24'sd8388607, 10'd1023, 1'b0);
      wait_drained();
      load_loop_settings(24'sd8388607, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(-24'sd8388608, 10'd512, 1'b1);
      send_beat(24'sd0, 10'd0, 1'b0);
   endtask

   // well-formed turns under random settings and idling
   task automatic test_turns();
      for (int p = 0; p < 4; p++) begin
         wait_drained();
         if (p == 3) begin
            load_loop_settings(24'(int'($urandom_range(0, 2000000)) - 1000000),
                               16'hFFFF, 16'hFFFF, 16'hFFFF);
         end else begin
            load_loop_settings(24'(int'($urandom_range(0, 2000000)) - 1000000),
                               16'($urandom_range(0, 30000)), 16'($urandom_range(0, 4000)),
                               16'($urandom_range(0, 30000)));
         end
         for (int t = 0; t < 8; t++) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            run_turn(int'($urandom_range(12, 40)));
         end
      end
   endtask

   // unstructured beats over the whole field ranges
   task automatic test_noise();
      for (int p = 0; p < 2; p++) begin
         wait_drained();
         if (p == 0) begin
            load_loop_settings(-24'sd8388608, 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
         end else begin
            load_loop_settings(24'sd8388607, 16'hFFFF, 16'h0000, 16'hFFFF);
         end
         for (int k = 0; k < 100; k++) begin
            if (k % 25 == 0) begin
               tx_idle = ($urandom_range(0, 2) != 0);
               rx_idle = ($urandom_range(0, 2) != 0);
            end
            send_beat(24'($urandom), 10'($urandom_range(0, 1023)),
                      $urandom_range(0, 7) == 0);
         end
      end
   endtask

   // receiver holds off while the sender streams, then after all responses both sides idle at random
   task automatic test_pressure();
      wait_drained();
      load_loop_settings(24'(int'($urandom_range(0, 20000)) - 10000),
                         16'($urandom_range(0, 20000)), 16'($urandom_range(0, 2000)),
                         16'($urandom_range(0, 20000)));
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      rx_hold_cycles = 80;
      run_turn(24);
      wait_drained();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      run_turn(16);
   endtask

   // receiver: random or held-off stall ahead of each response beat
   initial begin
      int gap;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         gap = rx_idle ? $urandom_range(0, 15) : 0;
         if (rx_hold_cycles > 0) begin
            gap = rx_hold_cycles;
            rx_hold_cycles = 0;
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare each response beat with the oldest predicted one
   always @(posedge clock) begin : check_beat
      drive_result_type want;
      if (!reset && req_valid && !req_ready) input_stalls++;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_q.size() == 0) begin
            bad_beats++;
            if (bad_beats <= 10) $display("response beat with nothing outstanding");
         end else begin
            want = drive_q.pop_front();
            beats_checked++;
            if (rsp_turn_done) done_beats++;
            if (rsp_right_drive == pidts_pkg::DRIVE_LIMIT ||
                rsp_right_drive == -pidts_pkg::DRIVE_LIMIT)
               clamped_beats++;
            if (rsp_left_drive !== want.left || rsp_right_drive !== want.right ||
                rsp_turn_done !== want.done) begin
               bad_beats++;
               if (bad_beats <= 10)
                  $display({"beat %0d: expected left %0d right %0d done %0b,",
                            " got left %0d right %0d done %0b"},
                           beats_checked, want.left, want.right, want.done,
                           rsp_left_drive, rsp_right_drive, rsp_turn_done);
            end
         end
      end
   end

   // run limit
   initial begin
      #4_000_000;
      $display("pid_turn_with_settle_detect test failed");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_measured_heading = '0;
      req_elapsed_ms       = '0;
      req_restart          = 1'b0;
      csr_write_en         = 1'b0;
      csr_index            = pidts_pkg::CSR_TARGET_HEADING;
      csr_wdata            = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_turns();
      test_noise();
      test_pressure();

      wait_drained();
      repeat (16) @(posedge clock);
      $display("covered %0d request beats over directed, turn, noise and back-pressure runs",
               beats_sent);
      $display("%0d responses checked, %0d with turn done, %0d clamped, %0d stalled inputs",
               beats_checked, done_beats, clamped_beats, input_stalls);
      if (bad_beats == 0 && drive_q.size() == 0) begin
         $display("pid_turn_with_settle_detect test passed");
      end else begin
         $display("pid_turn_with_settle_detect test failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/pidts_pkg.sv
rtl/pidts_loop.sv
rtl/pidts_mac.sv
rtl/pidts_settle.sv
rtl/pid_turn_with_settle_detect.sv
rtl/pidts_checker.sv
sim/tb_top.sv
